// ===== src/mau_pkg.sv =====
// Shared types and constants for the modular arithmetic unit.
// No dependencies.
package mau_pkg;

  // Width of the signed raw value taken by the reduce action.
  localparam int RAW_WIDTH = 64;

  // Modulus loaded at reset (a prime).
  localparam logic [63:0] MOD_RESET = 64'd1000000007;

  typedef enum logic [2:0] {
    ACT_ADD    = 3'd0,
    ACT_SUB    = 3'd1,
    ACT_MUL    = 3'd2,
    ACT_DIV    = 3'd3,
    ACT_INV    = 3'd4,
    ACT_POW    = 3'd5,
    ACT_NEG    = 3'd6,
    ACT_REDUCE = 3'd7
  } action_t;

endpackage

// ===== src/modular_arithmetic_unit_core.sv =====
// Modular arithmetic unit: one residue per input word, modulo a programmable modulus.
// Bit-serial datapath: one shared shift/compare-subtract unit plus a serial multiplier.
// Depends on mau_pkg.
//
// Takes one word at a time; in_stall is high from acceptance until the result has
// been moved into the output register, and the next word can enter while that result
// still waits there. A modulus below 2 gives 0 without any reduction. Every other
// word first reduces both operands (a, then b) in the shared unit, then passes a
// dispatch state; add, subtract and negate then go on to load the output register.
// A multiply adds a serial multiply (two half-steps per multiplier bit) and a result
// state. Reduce adds a serial reduction of the 64-bit signed raw value. Inverse runs
// Euclid steps, each a long division in the shared unit plus a check and an update
// state (up to about 45 steps for a 31-bit modulus), then a fix-up state; divide is
// an inverse followed by a multiply. Power takes, per exponent bit, a multiply when
// the bit is set and a square while higher bits remain, E = EXPONENT_WIDTH bits at
// most, after an inverse for a negative exponent.
module modular_arithmetic_unit_core #(
  parameter int RESIDUE_WIDTH  = 31,
  parameter int EXPONENT_WIDTH = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [RESIDUE_WIDTH-1:0]     cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  mau_pkg::action_t             in_action,
  input  logic [RESIDUE_WIDTH-1:0]     in_operand_a,
  input  logic [RESIDUE_WIDTH-1:0]     in_operand_b,
  input  logic [EXPONENT_WIDTH-1:0]    in_exponent,
  input  logic [mau_pkg::RAW_WIDTH-1:0] in_raw_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [RESIDUE_WIDTH-1:0]     out_result
);
  import mau_pkg::*;

  localparam int W  = RESIDUE_WIDTH;
  localparam int E  = EXPONENT_WIDTH;
  localparam int XW = RESIDUE_WIDTH + 3;

  typedef enum logic [3:0] {
    S_IDLE, S_RED_A, S_RED_B, S_DISPATCH, S_RED_RAW, S_MUL, S_MUL_RES,
    S_INV_CHK, S_INV_DIV, S_INV_UPD, S_INV_FIN, S_POW_STEP, S_POW_ACC,
    S_POW_SQ, S_DONE
  } state_t;

  state_t                  state_r, mret_r;
  logic [W-1:0]            m_r;
  action_t                 act_r;
  logic [W-1:0]            opb_r;
  logic [E-1:0]            e_r;
  logic [RAW_WIDTH-1:0]    raw_r;
  logic                    neg_r;
  logic [W-1:0]            a_r, b_r;
  logic [RAW_WIDTH-1:0]    sh_r;
  logic [6:0]              cnt_r;
  logic [W-1:0]            red_r;
  logic [W-1:0]            mx_r, my_r, acc_r;
  logic                    ph_r;
  logic [W-1:0]            g_r, r_r;
  logic signed [XW-1:0]    x_r, y_r, t_r;
  logic [W-1:0]            base_r, accp_r;
  logic [E-1:0]            mag_r;
  logic [W-1:0]            res_r;
  logic                    out_valid_r;
  logic [W-1:0]            out_result_r;

  // shared shift/compare-subtract unit: remainder step for mod and long division
  logic [W-1:0]            dvs;
  logic [W:0]              red_d;
  logic                    red_ge;
  logic [W-1:0]            red_n;
  logic signed [XW-1:0]    t_n;
  // serial multiplier half-steps
  logic [W:0]              dbl, addv;
  logic [W-1:0]            dbl_n, add_n;
  // simple actions and inverse fix-up
  logic [W:0]              sum_ab;
  logic [W-1:0]            add_res, sub_res, neg_res;
  logic signed [XW-1:0]    xa;
  logic [W-1:0]            xf;
  logic [E-1:0]            mag_neg;
  logic [E-1:0]            mag_shr;

  always_comb begin
    dvs    = (state_r == S_INV_DIV) ? r_r : m_r;
    red_d  = {red_r, sh_r[RAW_WIDTH-1]};
    red_ge = red_d >= {1'b0, dvs};
    red_n  = red_ge ? W'(red_d - {1'b0, dvs}) : W'(red_d);
    t_n    = (t_r <<< 1) + (red_ge ? y_r : '0);

    dbl    = {acc_r, 1'b0};
    dbl_n  = (dbl >= {1'b0, m_r}) ? W'(dbl - {1'b0, m_r}) : W'(dbl);
    addv   = {1'b0, acc_r} + {1'b0, (my_r[W-1] ? mx_r : '0)};
    add_n  = (addv >= {1'b0, m_r}) ? W'(addv - {1'b0, m_r}) : W'(addv);

    sum_ab  = {1'b0, a_r} + {1'b0, b_r};
    add_res = (sum_ab >= {1'b0, m_r}) ? W'(sum_ab - {1'b0, m_r}) : W'(sum_ab);
    sub_res = (a_r >= b_r) ? (a_r - b_r) : W'({1'b0, a_r} + {1'b0, m_r} - {1'b0, b_r});
    neg_res = (a_r == '0) ? '0 : (m_r - a_r);

    xa = x_r[XW-1] ? (x_r + $signed({3'b000, m_r})) : x_r;
    xf = (xa >= $signed({3'b000, m_r})) ? W'(xa - $signed({3'b000, m_r})) : W'(xa);

    mag_neg = (~e_r) + {{(E-1){1'b0}}, 1'b1};
    mag_shr = mag_r >> 1;
  end

  assign in_stall   = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      m_r         <= W'(MOD_RESET);
    end else begin
      if (cfg_we) m_r <= cfg_wdata;
      // S_DONE owns the output register in its own cycle
      if (out_valid_r && !out_stall && state_r != S_DONE) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            act_r <= in_action;
            opb_r <= in_operand_b;
            e_r   <= in_exponent;
            raw_r <= in_raw_value;
            red_r <= '0;
            cnt_r <= '0;
            sh_r  <= {in_operand_a, {(RAW_WIDTH-W){1'b0}}};
            if (m_r < W'(2)) begin
              res_r   <= '0;
              state_r <= S_DONE;
            end else begin
              state_r <= S_RED_A;
            end
          end
        end
        S_RED_A: begin
          if (cnt_r == 7'(W-1)) begin
            a_r     <= red_n;
            red_r   <= '0;
            cnt_r   <= '0;
            sh_r    <= {opb_r, {(RAW_WIDTH-W){1'b0}}};
            state_r <= S_RED_B;
          end else begin
            red_r <= red_n;
            sh_r  <= sh_r << 1;
            cnt_r <= cnt_r + 7'd1;
          end
        end
        S_RED_B: begin
          red_r <= red_n;
          sh_r  <= sh_r << 1;
          cnt_r <= cnt_r + 7'd1;
          if (cnt_r == 7'(W-1)) begin
            b_r     <= red_n;
            state_r <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          unique case (act_r)
            ACT_ADD: begin
              res_r   <= add_res;
              state_r <= S_DONE;
            end
            ACT_SUB: begin
              res_r   <= sub_res;
              state_r <= S_DONE;
            end
            ACT_NEG: begin
              res_r   <= neg_res;
              state_r <= S_DONE;
            end
            ACT_MUL: begin
              mx_r    <= a_r;
              my_r    <= b_r;
              acc_r   <= '0;
              ph_r    <= 1'b0;
              cnt_r   <= '0;
              mret_r  <= S_MUL_RES;
              state_r <= S_MUL;
            end
            ACT_DIV, ACT_INV: begin
              g_r     <= m_r;
              r_r     <= (act_r == ACT_DIV) ? b_r : a_r;
              x_r     <= '0;
              y_r     <= XW'(1);
              state_r <= S_INV_CHK;
            end
            ACT_POW: begin
              accp_r <= W'(1);
              if (e_r[E-1]) begin
                mag_r   <= mag_neg;
                g_r     <= m_r;
                r_r     <= a_r;
                x_r     <= '0;
                y_r     <= XW'(1);
                state_r <= S_INV_CHK;
              end else begin
                mag_r   <= e_r;
                base_r  <= a_r;
                state_r <= S_POW_STEP;
              end
            end
            ACT_REDUCE: begin
              neg_r   <= raw_r[RAW_WIDTH-1];
              sh_r    <= raw_r[RAW_WIDTH-1] ? (~raw_r + RAW_WIDTH'(1)) : raw_r;
              red_r   <= '0;
              cnt_r   <= '0;
              state_r <= S_RED_RAW;
            end
            default: state_r <= S_IDLE;
          endcase
        end
        S_RED_RAW: begin
          red_r <= red_n;
          sh_r  <= sh_r << 1;
          cnt_r <= cnt_r + 7'd1;
          if (cnt_r == 7'(RAW_WIDTH-1)) begin
            res_r   <= (neg_r && red_n != '0) ? (m_r - red_n) : red_n;
            state_r <= S_DONE;
          end
        end
        S_MUL: begin
          // doubling half-step, then conditional add of the multiplicand
          if (!ph_r) begin
            acc_r <= dbl_n;
            ph_r  <= 1'b1;
          end else begin
            acc_r <= add_n;
            my_r  <= my_r << 1;
            ph_r  <= 1'b0;
            cnt_r <= cnt_r + 7'd1;
            if (cnt_r == 7'(W-1)) state_r <= mret_r;
          end
        end
        S_MUL_RES: begin
          res_r   <= acc_r;
          state_r <= S_DONE;
        end
        S_INV_CHK: begin
          if (r_r == '0) begin
            state_r <= S_INV_FIN;
          end else begin
            sh_r    <= {g_r, {(RAW_WIDTH-W){1'b0}}};
            red_r   <= '0;
            t_r     <= '0;
            cnt_r   <= '0;
            state_r <= S_INV_DIV;
          end
        end
        S_INV_DIV: begin
          // long division g / r, quotient times y built alongside
          red_r <= red_n;
          t_r   <= t_n;
          sh_r  <= sh_r << 1;
          cnt_r <= cnt_r + 7'd1;
          if (cnt_r == 7'(W-1)) state_r <= S_INV_UPD;
        end
        S_INV_UPD: begin
          g_r     <= r_r;
          r_r     <= red_r;
          x_r     <= y_r;
          y_r     <= x_r - t_r;
          state_r <= S_INV_CHK;
        end
        S_INV_FIN: begin
          unique case (act_r)
            ACT_DIV: begin
              mx_r    <= a_r;
              my_r    <= xf;
              acc_r   <= '0;
              ph_r    <= 1'b0;
              cnt_r   <= '0;
              mret_r  <= S_MUL_RES;
              state_r <= S_MUL;
            end
            ACT_POW: begin
              base_r  <= xf;
              state_r <= S_POW_STEP;
            end
            default: begin
              res_r   <= xf;
              state_r <= S_DONE;
            end
          endcase
        end
        S_POW_STEP: begin
          if (mag_r == '0) begin
            res_r   <= accp_r;
            state_r <= S_DONE;
          end else if (mag_r[0]) begin
            mx_r    <= accp_r;
            my_r    <= base_r;
            acc_r   <= '0;
            ph_r    <= 1'b0;
            cnt_r   <= '0;
            mret_r  <= S_POW_ACC;
            state_r <= S_MUL;
          end else begin
            state_r <= S_POW_ACC;
          end
        end
        S_POW_ACC: begin
          if (mag_r[0]) accp_r <= acc_r;
          mag_r <= mag_shr;
          if (mag_shr != '0) begin
            mx_r    <= base_r;
            my_r    <= base_r;
            acc_r   <= '0;
            ph_r    <= 1'b0;
            cnt_r   <= '0;
            mret_r  <= S_POW_SQ;
            state_r <= S_MUL;
          end else begin
            state_r <= S_POW_STEP;
          end
        end
        S_POW_SQ: begin
          base_r  <= acc_r;
          state_r <= S_POW_STEP;
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r  <= 1'b1;
            out_result_r <= res_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_result_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((m_r < W'(2)) ? (out_result_r == '0) : (out_result_r < m_r)))
    else $error("result not below modulus");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r != S_IDLE))
    else $error("accepted word did not start work");

  a_div_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INV_DIV) |-> (red_r < r_r))
    else $error("division remainder not below divisor");
`endif

endmodule
